[hw/rtl/jsu_pkg.sv]
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] BS_CODE   = 8'h08;
  localparam logic [7:0] FF_CODE   = 8'h0c;
  localparam logic [7:0] LF_CODE   = 8'h0a;
  localparam logic [7:0] CR_CODE   = 8'h0d;
  localparam logic [7:0] TAB_CODE  = 8'h09;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_QUOTE    = 4'd1,
    ERR_CTRL     = 4'd2,
    ERR_ESC      = 4'd3,
    ERR_HEX      = 4'd4,
    ERR_NO_LOW   = 4'd5,
    ERR_BAD_LOW  = 4'd6,
    ERR_UNPAIRED = 4'd7,
    ERR_END      = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    err_t       error_code;
    logic       last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    HEAD_NONE = 3'd0,
    HEAD_BYTE = 3'd1,
    HEAD_UTF8 = 3'd2,
    HEAD_DONE = 3'd3,
    HEAD_ERR  = 3'd4
  } head_t;

  typedef struct packed {
    head_t       head;
    logic [20:0] cp;
    logic [2:0]  n_head;
    err_t        err;
    logic        tail_end;
  } job_t;

endpackage

[hw/rtl/json_string_unescape.sv]
// A byte's result passes through the queue memory and then the back end's output register.
// Throughput: one byte per cycle while each byte yields at most one result and out_ready stays high.
// The back end emits one result per cycle from its output register while out_ready is high,
// so a \u escape yielding k results (up to 5 with the end-of-text error) keeps its queue entry until all k are out.
// Reset: synchronous, active-low rst_n empties the queue and output, and waits for a quote.
module json_string_unescape #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  logic          take;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  jsu_pkg::job_t job_in;
  jsu_pkg::job_t job_head;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .push    (push),
    .job     (job_in)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job_in),
    .pop       (pop),
    .head_data (job_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_close_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != jsu_pkg::KIND_DATA) |-> out_data.last_of_run)
    else $error("close or error result not last of run");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == jsu_pkg::KIND_ERR) ==
                   (out_data.error_code != jsu_pkg::ERR_NONE)))
    else $error("error code inconsistent with kind");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue drained while empty");

endmodule

[hw/rtl/jsu_front.sv]
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  jsu_pkg::in_t  in_data,
  output logic          push,
  output jsu_pkg::job_t job
);

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_BODY    = 7'b0000010,
    PH_ESC     = 7'b0000100,
    PH_HEX1    = 7'b0001000,
    PH_SEEK_BS = 7'b0010000,
    PH_SEEK_U  = 7'b0100000,
    PH_HEX2    = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] code;

  assign c = in_data.in_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code = {acc_r, hex_val};

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    hs_nxt       = hs_r;
    job.head     = jsu_pkg::HEAD_NONE;
    job.cp       = '0;
    job.n_head   = 3'd0;
    job.err      = jsu_pkg::ERR_NONE;
    job.tail_end = 1'b0;
    case (phase_r)
      PH_BODY: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          job.head   = jsu_pkg::HEAD_DONE;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end else if (c < jsu_pkg::CH_SPACE) begin
          job.head   = jsu_pkg::HEAD_ERR;
          job.err    = jsu_pkg::ERR_CTRL;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          job.head   = jsu_pkg::HEAD_BYTE;
          job.cp     = {13'd0, c};
          job.n_head = 3'd1;
        end
      end
      PH_ESC: begin
        job.head   = jsu_pkg::HEAD_BYTE;
        job.n_head = 3'd1;
        phase_nxt  = PH_BODY;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: job.cp = {13'd0, c};
          jsu_pkg::CH_B: job.cp = {13'd0, jsu_pkg::BS_CODE};
          jsu_pkg::CH_F: job.cp = {13'd0, jsu_pkg::FF_CODE};
          jsu_pkg::CH_N: job.cp = {13'd0, jsu_pkg::LF_CODE};
          jsu_pkg::CH_R: job.cp = {13'd0, jsu_pkg::CR_CODE};
          jsu_pkg::CH_T: job.cp = {13'd0, jsu_pkg::TAB_CODE};
          jsu_pkg::CH_U: begin
            job.head   = jsu_pkg::HEAD_NONE;
            job.n_head = 3'd0;
            phase_nxt  = PH_HEX1;
            cnt_nxt    = 2'd0;
            acc_nxt    = '0;
          end
          default: begin
            job.head  = jsu_pkg::HEAD_ERR;
            job.err   = jsu_pkg::ERR_ESC;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (!hex_ok) begin
          job.head   = jsu_pkg::HEAD_ERR;
          job.err    = jsu_pkg::ERR_HEX;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = {acc_r[7:0], hex_val};
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt = 2'd0;
          if (phase_r == PH_HEX1) begin
            if (code[15:10] == 6'b110110) begin
              hs_nxt    = code[9:0];
              phase_nxt = PH_SEEK_BS;
            end else if (code[15:10] == 6'b110111) begin
              job.head   = jsu_pkg::HEAD_ERR;
              job.err    = jsu_pkg::ERR_UNPAIRED;
              job.n_head = 3'd1;
              phase_nxt  = PH_IDLE;
            end else begin
              job.head  = jsu_pkg::HEAD_UTF8;
              job.cp    = {5'd0, code};
              phase_nxt = PH_BODY;
              if (code[15:7] == 9'd0) begin
                job.n_head = 3'd1;
              end else if (code[15:11] == 5'd0) begin
                job.n_head = 3'd2;
              end else begin
                job.n_head = 3'd3;
              end
            end
          end else begin
            if (code[15:10] != 6'b110111) begin
              job.head   = jsu_pkg::HEAD_ERR;
              job.err    = jsu_pkg::ERR_BAD_LOW;
              job.n_head = 3'd1;
              phase_nxt  = PH_IDLE;
            end else begin
              job.head   = jsu_pkg::HEAD_UTF8;
              job.cp     = jsu_pkg::SUPP_BASE + {1'b0, hs_r, code[9:0]};
              job.n_head = 3'd4;
              phase_nxt  = PH_BODY;
            end
          end
        end
      end
      PH_SEEK_BS: begin
        if (c == jsu_pkg::CH_BSLASH) begin
          phase_nxt = PH_SEEK_U;
        end else begin
          job.head   = jsu_pkg::HEAD_ERR;
          job.err    = jsu_pkg::ERR_NO_LOW;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end
      end
      PH_SEEK_U: begin
        if (c == jsu_pkg::CH_U) begin
          phase_nxt = PH_HEX2;
          cnt_nxt   = 2'd0;
          acc_nxt   = '0;
        end else begin
          job.head   = jsu_pkg::HEAD_ERR;
          job.err    = jsu_pkg::ERR_NO_LOW;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end
      end
      default: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          phase_nxt = PH_BODY;
        end else begin
          job.head   = jsu_pkg::HEAD_ERR;
          job.err    = jsu_pkg::ERR_QUOTE;
          job.n_head = 3'd1;
          phase_nxt  = PH_IDLE;
        end
      end
    endcase
    if (in_data.is_last && (phase_nxt != PH_IDLE)) begin
      job.tail_end = 1'b1;
      phase_nxt    = PH_IDLE;
    end
  end

  assign push = take && ((job.head != jsu_pkg::HEAD_NONE) || job.tail_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r <= acc_nxt;
      hs_r  <= hs_nxt;
    end
  end

endmodule

[hw/rtl/jsu_queue.sv]
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_data,
  input  logic          pop,
  output jsu_pkg::job_t head_data,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/jsu_back.sv]
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::job_t job,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  logic          out_valid_r;
  jsu_pkg::out_t out_r, res;
  logic [2:0]    idx_r;
  logic [2:0]    total;
  logic          load;
  logic          is_final;
  logic [7:0]    ubyte;

  assign total    = job.n_head + {2'd0, job.tail_end};
  assign is_final = (idx_r == total - 3'd1);
  assign load     = !q_empty && (!out_valid_r || out_ready);
  assign pop      = load && is_final;

  always_comb begin
    case (job.n_head)
      3'd1: ubyte = job.cp[7:0];
      3'd2: ubyte = (idx_r == 3'd0) ? {3'b110, job.cp[10:6]} : {2'b10, job.cp[5:0]};
      3'd3: begin
        case (idx_r)
          3'd0:    ubyte = {4'b1110, job.cp[15:12]};
          3'd1:    ubyte = {2'b10, job.cp[11:6]};
          default: ubyte = {2'b10, job.cp[5:0]};
        endcase
      end
      default: begin
        case (idx_r)
          3'd0:    ubyte = {5'b11110, job.cp[20:18]};
          3'd1:    ubyte = {2'b10, job.cp[17:12]};
          3'd2:    ubyte = {2'b10, job.cp[11:6]};
          default: ubyte = {2'b10, job.cp[5:0]};
        endcase
      end
    endcase
  end

  always_comb begin
    res.out_byte    = 8'd0;
    res.kind        = jsu_pkg::KIND_ERR;
    res.error_code  = jsu_pkg::ERR_END;
    res.last_of_run = is_final;
    if (idx_r < job.n_head) begin
      case (job.head)
        jsu_pkg::HEAD_BYTE: begin
          res.out_byte   = job.cp[7:0];
          res.kind       = jsu_pkg::KIND_DATA;
          res.error_code = jsu_pkg::ERR_NONE;
        end
        jsu_pkg::HEAD_UTF8: begin
          res.out_byte   = ubyte;
          res.kind       = jsu_pkg::KIND_DATA;
          res.error_code = jsu_pkg::ERR_NONE;
        end
        jsu_pkg::HEAD_DONE: begin
          res.kind       = jsu_pkg::KIND_DONE;
          res.error_code = jsu_pkg::ERR_NONE;
        end
        default: begin
          res.error_code = job.err;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_final ? 3'd0 : idx_r + 3'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
